@@ rtl/swpl_pkg.sv @@
// ----------------------------------------------------------------------------
// swpl_pkg
// Shared widths, reset values, register indexes and verdict codes of the
// sliding window packet limiter.
// ----------------------------------------------------------------------------
package swpl_pkg;

  // default sizing of the stamp store
  localparam int FIFO_DEPTH_DEF = 1024;
  localparam int STAMP_BITS_DEF = 48;

  // payload field widths
  localparam int ARRIVAL_W  = 48;
  localparam int BYTES_W    = 16;
  localparam int VERDICT_W  = 2;
  localparam int TOTAL_W    = 32;
  localparam int PEAK_W     = 11;

  // configuration register widths
  localparam int CFG_CAP_W    = 11;
  localparam int CFG_WINDOW_W = 32;
  localparam int CFG_LIMIT_W  = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT    = 2'd2;

  // configuration reset values
  localparam logic [CFG_CAP_W-1:0]    CAPACITY_RST = 11'd1024;
  localparam logic [CFG_WINDOW_W-1:0] WINDOW_RST   = 32'd1000;
  localparam logic [CFG_LIMIT_W-1:0]  LIMIT_RST    = 11'd1024;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // decision codes
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_FULL   = 2'd1,
    VERDICT_RATE   = 2'd2
  } verdict_e;

endpackage

@@ rtl/swpl_if.sv @@
// ----------------------------------------------------------------------------
// swpl_if
// Valid/ready channels of the limiter: packet in, result out, register write.
// ----------------------------------------------------------------------------

// packet channel
interface swpl_pkt_if import swpl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ARRIVAL_W-1:0] arrival_ms;
  logic [BYTES_W-1:0]   packet_bytes;

  modport source (output valid, output arrival_ms, output packet_bytes, input ready);
  modport sink   (input valid, input arrival_ms, input packet_bytes, output ready);
endinterface

// result channel
interface swpl_res_if import swpl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [ARRIVAL_W-1:0] echo_ms;
  logic [BYTES_W-1:0]   echo_bytes;
  logic [TOTAL_W-1:0]   accepted_total;
  logic [TOTAL_W-1:0]   buffer_reject_total;
  logic [TOTAL_W-1:0]   rate_reject_total;
  logic [PEAK_W-1:0]    peak_held;

  modport source (output valid, output verdict, output echo_ms, output echo_bytes,
                  output accepted_total, output buffer_reject_total,
                  output rate_reject_total, output peak_held, input ready);
  modport sink   (input valid, input verdict, input echo_ms, input echo_bytes,
                  input accepted_total, input buffer_reject_total,
                  input rate_reject_total, input peak_held, output ready);
endinterface

// register write channel
interface swpl_cfg_if import swpl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/swpl_stamp_ram.sv @@
// ----------------------------------------------------------------------------
// swpl_stamp_ram
// Arrival stamp store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swpl_stamp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data registered
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/swpl_expiry_unit.sv @@
// ----------------------------------------------------------------------------
// swpl_expiry_unit
// Expiry test of the oldest stamp: arrival >= oldest + window, summed one bit
// wider than the wider operand so it never wraps.
// ----------------------------------------------------------------------------
module swpl_expiry_unit import swpl_pkg::*; #(
  parameter int STAMP_BITS = 48
) (
  input  logic [STAMP_BITS-1:0]   now_i,
  input  logic [STAMP_BITS-1:0]   oldest_i,
  input  logic [CFG_WINDOW_W-1:0] window_i,
  output logic                    expired_o
);

  localparam int SumW = ((STAMP_BITS > CFG_WINDOW_W) ? STAMP_BITS : CFG_WINDOW_W) + 1;

  logic [SumW-1:0] limit_sum;

  // stamp plus window, then compare
  assign limit_sum = SumW'(oldest_i) + SumW'(window_i);
  assign expired_o = (SumW'(now_i) >= limit_sum);

endmodule

@@ rtl/sliding_window_packet_limiter.sv @@
// ----------------------------------------------------------------------------
// sliding_window_packet_limiter
// Sliding window rate limiter over a log of accepted arrival stamps.
// ----------------------------------------------------------------------------
// One packet is judged at a time, held in the payload registers while the
// purge pops its expired stamps through a single expiry comparator fed by
// the registered read port of the stamp memory, one stamp a cycle. With the
// output free, the decision is taken in the cycle the oldest stamp is found
// live or the log is empty. The packet port is ready only while no packet is
// in work; a finished result waits in the output register, and the next
// packet may be taken meanwhile. Totals and the peak shown with a result are
// those after that packet. The stamp memory needs no clearing after reset.
// Register writes are taken at any time but must only be issued while idle.
// ----------------------------------------------------------------------------
module sliding_window_packet_limiter import swpl_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  swpl_pkt_if.sink   pkt_i,
  swpl_res_if.source res_o,
  swpl_cfg_if.sink   cfg_i
);

  localparam int AddrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW  = $clog2(FIFO_DEPTH + 1);
  localparam int CmpW  = (CntW > CFG_CAP_W) ? CntW : CFG_CAP_W;
  localparam logic [AddrW-1:0] LastSlot = AddrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(FIFO_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_PURGE
  } state_e;

  state_e state_q, state_d;

  logic [CFG_CAP_W-1:0]    cap_q, cap_d;
  logic [CFG_WINDOW_W-1:0] window_q, window_d;
  logic [CFG_LIMIT_W-1:0]  limit_q, limit_d;

  logic [STAMP_BITS-1:0] now_q, now_d;
  logic [BYTES_W-1:0]    bytes_q, bytes_d;
  logic [AddrW-1:0]      head_q, head_d;
  logic [AddrW-1:0]      tail_q, tail_d;
  logic [CntW-1:0]       held_q, held_d;
  logic [CntW-1:0]       peak_q, peak_d;
  logic [TOTAL_W-1:0]    acc_q, acc_d;
  logic [TOTAL_W-1:0]    full_q, full_d;
  logic [TOTAL_W-1:0]    rate_q, rate_d;

  logic                 res_valid_q, res_valid_d;
  verdict_e             verdict_q, verdict_d;
  logic [ARRIVAL_W-1:0] echo_ms_q, echo_ms_d;
  logic [BYTES_W-1:0]   echo_bytes_q, echo_bytes_d;

  logic                  wr_en;
  logic [STAMP_BITS-1:0] oldest;
  logic                  expired;
  logic                  out_free;
  logic [CntW-1:0]       held_inc;

  // stamp store, read always at the head that the next cycle sees
  swpl_stamp_ram #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (STAMP_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail_q),
    .wr_data_i (now_q),
    .rd_addr_i (head_d),
    .rd_data_o (oldest)
  );

  // shared expiry comparator
  swpl_expiry_unit #(
    .STAMP_BITS (STAMP_BITS)
  ) u_expiry (
    .now_i     (now_q),
    .oldest_i  (oldest),
    .window_i  (window_q),
    .expired_o (expired)
  );

  assign pkt_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free    = !res_valid_q || res_o.ready;
  assign held_inc    = held_q + CntW'(1);

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    window_d     = window_q;
    limit_d      = limit_q;
    now_d        = now_q;
    bytes_d      = bytes_q;
    head_d       = head_q;
    tail_d       = tail_q;
    held_d       = held_q;
    peak_d       = peak_q;
    acc_d        = acc_q;
    full_d       = full_q;
    rate_d       = rate_q;
    res_valid_d  = res_valid_q;
    verdict_d    = verdict_q;
    echo_ms_d    = echo_ms_q;
    echo_bytes_d = echo_bytes_q;
    wr_en        = 1'b0;

    // register writes
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IDX_CAPACITY: cap_d    = cfg_i.data[CFG_CAP_W-1:0];
        CFG_IDX_WINDOW:   window_d = cfg_i.data[CFG_WINDOW_W-1:0];
        CFG_IDX_LIMIT:    limit_d  = cfg_i.data[CFG_LIMIT_W-1:0];
        default:          ;
      endcase
    end

    // result taken
    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (pkt_i.valid) begin
          now_d   = STAMP_BITS'(pkt_i.arrival_ms);
          bytes_d = pkt_i.packet_bytes;
          state_d = ST_PURGE;
        end
      end
      ST_PURGE: begin
        if (held_q != '0 && expired) begin
          // pop one expired stamp
          head_d = (head_q == LastSlot) ? '0 : head_q + AddrW'(1);
          held_d = held_q - CntW'(1);
        end else if (out_free) begin
          // decide and present the result
          if (CmpW'(held_q) >= CmpW'(cap_q) || held_q >= DepthCnt) begin
            full_d    = (full_q == TOTAL_MAX) ? full_q : full_q + TOTAL_W'(1);
            verdict_d = VERDICT_FULL;
          end else if (CmpW'(held_q) >= CmpW'(limit_q)) begin
            rate_d    = (rate_q == TOTAL_MAX) ? rate_q : rate_q + TOTAL_W'(1);
            verdict_d = VERDICT_RATE;
          end else begin
            wr_en     = 1'b1;
            tail_d    = (tail_q == LastSlot) ? '0 : tail_q + AddrW'(1);
            held_d    = held_inc;
            acc_d     = (acc_q == TOTAL_MAX) ? acc_q : acc_q + TOTAL_W'(1);
            verdict_d = VERDICT_ACCEPT;
            if (held_inc > peak_q) begin
              peak_d = held_inc;
            end
          end
          echo_ms_d    = ARRIVAL_W'(now_q);
          echo_bytes_d = bytes_q;
          res_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= CAPACITY_RST;
      window_q     <= WINDOW_RST;
      limit_q      <= LIMIT_RST;
      head_q       <= '0;
      tail_q       <= '0;
      held_q       <= '0;
      peak_q       <= '0;
      acc_q        <= '0;
      full_q       <= '0;
      rate_q       <= '0;
      res_valid_q  <= 1'b0;
      verdict_q    <= VERDICT_ACCEPT;
      echo_ms_q    <= '0;
      echo_bytes_q <= '0;
    end else begin
      state_q      <= state_d;
      cap_q        <= cap_d;
      window_q     <= window_d;
      limit_q      <= limit_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      held_q       <= held_d;
      peak_q       <= peak_d;
      acc_q        <= acc_d;
      full_q       <= full_d;
      rate_q       <= rate_d;
      res_valid_q  <= res_valid_d;
      verdict_q    <= verdict_d;
      echo_ms_q    <= echo_ms_d;
      echo_bytes_q <= echo_bytes_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    bytes_q <= bytes_d;
  end

  // counters only move at the next decision, which waits for this result
  assign res_o.valid               = res_valid_q;
  assign res_o.verdict             = verdict_q;
  assign res_o.echo_ms             = echo_ms_q;
  assign res_o.echo_bytes          = echo_bytes_q;
  assign res_o.accepted_total      = acc_q;
  assign res_o.buffer_reject_total = full_q;
  assign res_o.rate_reject_total   = rate_q;
  assign res_o.peak_held           = PEAK_W'(peak_q);

endmodule

@@ rtl/swpl_checker.sv @@
// ----------------------------------------------------------------------------
// swpl_checker
// Port-level checks of the limiter, bound to the top level.
// ----------------------------------------------------------------------------
module swpl_checker import swpl_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 pkt_valid_i,
  input logic                 pkt_ready_i,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input logic [VERDICT_W-1:0] verdict_i,
  input logic [ARRIVAL_W-1:0] echo_ms_i,
  input logic [BYTES_W-1:0]   echo_bytes_i,
  input logic [TOTAL_W-1:0]   acc_total_i,
  input logic [TOTAL_W-1:0]   full_total_i,
  input logic [TOTAL_W-1:0]   rate_total_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(verdict_i)
      && $stable(echo_ms_i) && $stable(echo_bytes_i))
    else $error("stalled result changed");

  // one packet in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_i && pkt_ready_i |=> !pkt_ready_i)
    else $error("packet taken while another is in work");

  // an accept verdict comes with a counted accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && verdict_i == VERDICT_ACCEPT |-> acc_total_i != '0)
    else $error("accept shown with zero accept total");

  // a buffer-full verdict comes with a counted rejection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && verdict_i == VERDICT_FULL |-> full_total_i != '0)
    else $error("buffer-full shown with zero total");

  // a rate verdict comes with a counted rejection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && verdict_i == VERDICT_RATE |-> rate_total_i != '0)
    else $error("rate reject shown with zero total");

endmodule

bind sliding_window_packet_limiter swpl_checker u_swpl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pkt_valid_i  (pkt_i.valid),
  .pkt_ready_i  (pkt_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .verdict_i    (res_o.verdict),
  .echo_ms_i    (res_o.echo_ms),
  .echo_bytes_i (res_o.echo_bytes),
  .acc_total_i  (res_o.accepted_total),
  .full_total_i (res_o.buffer_reject_total),
  .rate_total_i (res_o.rate_reject_total)
);
